@@ design/wfa_pkg.sv @@
// Package for the worst fit segment allocator: sizes, payload types, codes.
`timescale 1ns / 1ps
package wfa_pkg;

  localparam int MAX_SEGMENTS = 128;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  // free runs alternate with owned segments, plus the tail
  localparam int RUN_W        = $clog2(MAX_SEGMENTS / 2 + 2);
  localparam int SEG_W        = 16;
  localparam int BLK_W        = 8;
  localparam int DIV_CNT_W    = $clog2(SEG_W + 1);
  localparam logic [SEG_W-1:0] TOTAL_RESET = 16'd1024;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_NO_OWNER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_RUNS,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             req_type;
    logic [SEG_W-1:0] owner_id;
    logic [SEG_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEG_W-1:0] address;
    logic [SEG_W-1:0] free_total;
    logic [BLK_W-1:0] free_blocks;
    logic [SEG_W-1:0] avg_size;
  } out_item_t;

  typedef struct packed {
    logic [SEG_W-1:0] owner;
    logic [SEG_W-1:0] size;
  } seg_entry_t;

endpackage

@@ design/wfa_ram.sv @@
// Segment table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module wfa_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [wfa_pkg::IDX_W-1:0]  wr_addr,
  input  wfa_pkg::seg_entry_t        wr_data,
  input  logic [wfa_pkg::IDX_W-1:0]  rd_addr,
  output wfa_pkg::seg_entry_t        rd_data
);

  wfa_pkg::seg_entry_t mem [wfa_pkg::MAX_SEGMENTS];
  wfa_pkg::seg_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/wfa_div.sv @@
// Restoring divider, one quotient bit per cycle: free total over run count.
`timescale 1ns / 1ps
module wfa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wfa_pkg::SEG_W-1:0]  dividend,
  input  logic [wfa_pkg::RUN_W-1:0]  divisor,
  output logic                       done,
  output logic [wfa_pkg::SEG_W-1:0]  quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [wfa_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [wfa_pkg::RUN_W-1:0]     rem_r, rem_nxt;
  logic [wfa_pkg::RUN_W-1:0]     dsr_r, dsr_nxt;
  logic [wfa_pkg::SEG_W-1:0]     quo_r, quo_nxt;
  logic [wfa_pkg::RUN_W:0]       trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[wfa_pkg::SEG_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = wfa_pkg::DIV_CNT_W'(wfa_pkg::SEG_W);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = wfa_pkg::RUN_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[wfa_pkg::SEG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[wfa_pkg::RUN_W-1:0];
        quo_nxt = {quo_r[wfa_pkg::SEG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == wfa_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/worst_fit_segment_allocator.sv @@
// Worst fit segment allocator: request sequencer, table walks and result register.
//
// One request is taken at a time; in_ready is high only while the block is idle.
// An item goes through the table scan; when a free segment is split, a shift that opens
// a gap and a step that places the remainder; a recount of free runs and a total of the
// sizes over the updated list; the average when there is a free run (divider load, one
// quotient bit a cycle, done); and then holding the result until it is taken, with the
// single read port of the segment table setting the pace. A request rejected on intake
// skips the scan and shift.
// A write on cfg_we while idle sets the total size and empties the list at once.
`timescale 1ns / 1ps
module worst_fit_segment_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  wfa_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output wfa_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [wfa_pkg::SEG_W-1:0]    cfg_data
);

  localparam int IDX_W = wfa_pkg::IDX_W;
  localparam int CNT_W = wfa_pkg::CNT_W;
  localparam int RUN_W = wfa_pkg::RUN_W;
  localparam int SEG_W = wfa_pkg::SEG_W;

  wfa_pkg::state_t    state_r, state_nxt;
  wfa_pkg::in_item_t  req_r, req_nxt;
  wfa_pkg::status_t   status_r, status_nxt;
  wfa_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SEG_W-1:0]   addr_r, addr_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [SEG_W-1:0]   best_sz_r, best_sz_nxt;
  logic [SEG_W-1:0]   best_start_r, best_start_nxt;
  logic [SEG_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               dv_r, dv_nxt;
  logic [IDX_W-1:0]   didx_r, didx_nxt;
  logic               sh_done_r, sh_done_nxt;
  logic               prev_free_r, prev_free_nxt;
  logic [RUN_W-1:0]   runs_r, runs_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SEG_W-1:0]   free_r, free_nxt;
  logic [SEG_W-1:0]   total_r, total_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  wfa_pkg::seg_entry_t mem_wdata;
  wfa_pkg::seg_entry_t mem_rdata;
  logic                div_start;
  logic                div_done;
  logic [SEG_W-1:0]    div_quo;

  logic               issue;
  logic               full;
  logic [SEG_W-1:0]   tail;
  logic               cand;
  logic [RUN_W-1:0]   runs_fin;
  logic [CNT_W-1:0]   best_p1;

  wfa_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (ptr_r[IDX_W-1:0]),
    .rd_data (mem_rdata)
  );

  wfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (free_r),
    .divisor  (runs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      cnt_r       <= '0;
      free_r      <= wfa_pkg::TOTAL_RESET;
      total_r     <= wfa_pkg::TOTAL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
      cnt_r       <= cnt_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
    end
    req_r        <= req_nxt;
    status_r     <= status_nxt;
    out_r        <= out_nxt;
    addr_r       <= addr_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_sz_r    <= best_sz_nxt;
    best_start_r <= best_start_nxt;
    sum_r        <= sum_nxt;
    ptr_r        <= ptr_nxt;
    didx_r       <= didx_nxt;
    sh_done_r    <= sh_done_nxt;
    prev_free_r  <= prev_free_nxt;
    runs_r       <= runs_nxt;
  end

  assign issue    = ptr_r < cnt_r;
  assign full     = cnt_r == CNT_W'(wfa_pkg::MAX_SEGMENTS);
  assign tail     = (total_r > sum_r) ? total_r - sum_r : '0;
  assign best_p1  = {1'b0, best_r} + 1'b1;
  assign cand     = (mem_rdata.owner == '0) && (mem_rdata.size >= req_r.amount) &&
                    (!full || mem_rdata.size == req_r.amount);
  assign runs_fin = runs_r + RUN_W'((tail != '0) && !prev_free_r);

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    status_nxt     = status_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    addr_nxt       = addr_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_sz_nxt    = best_sz_r;
    best_start_nxt = best_start_r;
    sum_nxt        = sum_r;
    ptr_nxt        = ptr_r;
    dv_nxt         = 1'b0;
    didx_nxt       = didx_r;
    sh_done_nxt    = sh_done_r;
    prev_free_nxt  = prev_free_r;
    runs_nxt       = runs_r;
    cnt_nxt        = cnt_r;
    free_nxt       = free_r;
    total_nxt      = total_r;
    mem_we         = 1'b0;
    mem_waddr      = best_r;
    mem_wdata      = '{owner: req_r.owner_id, size: req_r.amount};
    div_start      = 1'b0;

    case (state_r)
      wfa_pkg::S_IDLE: begin
        if (cfg_we) begin
          total_nxt = cfg_data;
          free_nxt  = cfg_data;
          cnt_nxt   = '0;
        end
        ptr_nxt       = '0;
        sum_nxt       = '0;
        found_nxt     = 1'b0;
        addr_nxt      = '0;
        runs_nxt      = '0;
        prev_free_nxt = 1'b0;
        if (in_valid) begin
          req_nxt    = in_data;
          status_nxt = wfa_pkg::ST_OK;
          state_nxt  = wfa_pkg::S_SCAN;
          if (in_data.owner_id == '0) begin
            status_nxt = wfa_pkg::ST_NO_OWNER;
            state_nxt  = wfa_pkg::S_RUNS;
          end
          if (in_data.req_type == wfa_pkg::REQ_ALLOC) begin
            if (in_data.amount == '0) begin
              status_nxt = wfa_pkg::ST_NO_FIT;
              state_nxt  = wfa_pkg::S_RUNS;
            end else if (in_data.owner_id != '0 && in_data.amount > free_r) begin
              status_nxt = wfa_pkg::ST_NO_FREE;
              state_nxt  = wfa_pkg::S_RUNS;
            end
          end
        end
      end

      wfa_pkg::S_SCAN: begin
        if (issue) begin
          ptr_nxt  = ptr_r + 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = ptr_r[IDX_W-1:0];
        end
        if (dv_r) begin
          sum_nxt = sum_r + mem_rdata.size;
          if (req_r.req_type == wfa_pkg::REQ_ALLOC) begin
            if (cand && (!found_r || mem_rdata.size > best_sz_r)) begin
              found_nxt      = 1'b1;
              best_nxt       = didx_r;
              best_sz_nxt    = mem_rdata.size;
              best_start_nxt = sum_r;
            end
          end else if (!found_r && mem_rdata.owner == req_r.owner_id) begin
            found_nxt      = 1'b1;
            best_nxt       = didx_r;
            best_sz_nxt    = mem_rdata.size;
            best_start_nxt = sum_r;
          end
        end
        if (!issue && !dv_r) begin
          state_nxt = wfa_pkg::S_RUNS;
          ptr_nxt   = '0;
          sum_nxt   = '0;
          if (req_r.req_type == wfa_pkg::REQ_ALLOC) begin
            if (!full && tail >= req_r.amount && (!found_r || tail > best_sz_r)) begin
              // new entry after the last listed segment
              mem_we    = 1'b1;
              mem_waddr = cnt_r[IDX_W-1:0];
              addr_nxt  = sum_r;
              cnt_nxt   = cnt_r + 1'b1;
              free_nxt  = free_r - req_r.amount;
            end else if (!found_r) begin
              status_nxt = wfa_pkg::ST_NO_FIT;
            end else begin
              mem_we   = 1'b1;
              addr_nxt = best_start_r;
              free_nxt = free_r - req_r.amount;
              if (best_sz_r > req_r.amount) begin
                // open a gap behind the chosen entry for the remainder
                state_nxt   = wfa_pkg::S_SHIFT;
                ptr_nxt     = cnt_r - 1'b1;
                sh_done_nxt = best_p1 == cnt_r;
              end
            end
          end else if (found_r) begin
            mem_we    = 1'b1;
            mem_wdata = '{owner: '0, size: best_sz_r};
            addr_nxt  = best_start_r;
            free_nxt  = free_r + best_sz_r;
          end else begin
            status_nxt = wfa_pkg::ST_NO_OWNER;
          end
        end
      end

      wfa_pkg::S_SHIFT: begin
        if (!sh_done_r) begin
          dv_nxt   = 1'b1;
          didx_nxt = ptr_r[IDX_W-1:0];
          if (ptr_r == best_p1) begin
            sh_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = didx_r + 1'b1;
          mem_wdata = mem_rdata;
        end
        if (sh_done_r && !dv_r) begin
          state_nxt = wfa_pkg::S_PLACE;
        end
      end

      wfa_pkg::S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = best_p1[IDX_W-1:0];
        mem_wdata = '{owner: '0, size: best_sz_r - req_r.amount};
        cnt_nxt   = cnt_r + 1'b1;
        ptr_nxt   = '0;
        sum_nxt   = '0;
        state_nxt = wfa_pkg::S_RUNS;
      end

      wfa_pkg::S_RUNS: begin
        if (issue) begin
          ptr_nxt  = ptr_r + 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = ptr_r[IDX_W-1:0];
        end
        if (dv_r) begin
          sum_nxt       = sum_r + mem_rdata.size;
          prev_free_nxt = mem_rdata.owner == '0;
          if (mem_rdata.owner == '0 && !prev_free_r) begin
            runs_nxt = runs_r + 1'b1;
          end
        end
        if (!issue && !dv_r) begin
          runs_nxt = runs_fin;
          if (runs_fin == '0) begin
            out_nxt       = '{status: status_r, address: addr_r, free_total: free_r,
                              free_blocks: '0, avg_size: '0};
            out_valid_nxt = 1'b1;
            state_nxt     = wfa_pkg::S_OUT;
          end else begin
            state_nxt = wfa_pkg::S_DIV;
          end
        end
      end

      wfa_pkg::S_DIV: begin
        // first cycle here loads the divider with the final run count
        div_start = !sh_done_r;
        sh_done_nxt = 1'b1;
        if (div_done) begin
          out_nxt       = '{status: status_r, address: addr_r, free_total: free_r,
                            free_blocks: wfa_pkg::BLK_W'(runs_r), avg_size: div_quo};
          out_valid_nxt = 1'b1;
          state_nxt     = wfa_pkg::S_OUT;
        end
      end

      wfa_pkg::S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = wfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = wfa_pkg::S_IDLE;
      end
    endcase

    // the divider handshake reuses sh_done_r as its start flag
    if (state_r == wfa_pkg::S_RUNS && state_nxt == wfa_pkg::S_DIV) begin
      sh_done_nxt = 1'b0;
    end
  end

  assign in_ready  = state_r == wfa_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_ready_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(wfa_pkg::MAX_SEGMENTS))
    else $error("segment count above table depth");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= total_r)
    else $error("free total above managed size");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wfa_pkg::S_IDLE && in_valid && in_data.req_type == wfa_pkg::REQ_ALLOC &&
     in_data.amount > free_r) |=> status_r != wfa_pkg::ST_OK)
    else $error("oversized allocate not rejected");
`endif

endmodule
